/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Both expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BMM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bmm_pkg.sv */
package bmm_pkg;

  localparam int DIM_W        = 5;   // config register width
  localparam int ROW_W        = 4;
  localparam int COL_W        = 4;
  localparam int BYTE_W       = 8;
  localparam int CMD_W        = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int RESULT_LIMIT = 16;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  // item commands
  localparam logic [CMD_W-1:0] CMD_LOAD_LEFT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_RIGHT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE    = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_COLS = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [BYTE_W-1:0] value;
  } bmm_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] product;
    logic [ROW_W-1:0]  out_row;
    logic [COL_W-1:0]  out_col;
    logic              last_in_row;
  } bmm_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_LAST,
    ST_PUSH
  } bmm_state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // item beat taken this cycle
    logic start;     // begin a product row
    logic issue;     // read one element pair, advance k
    logic push;      // move accumulator into the result register
    logic next_col;  // advance column, clear k and accumulator
  } bmm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic start_ok;    // item is a compute that emits results
    logic k_last;
    logic c_last;
    logic inner_zero;
    logic out_free;
  } bmm_stat_t;

endpackage

/* rtl/byte_matrix_multiply.sv */
// byte_matrix_multiply: row-at-a-time product of two byte matrices.
//
// Item channel (item_valid / item_stall / item): a beat carries a command.
// Load-left and load-right write one element at (row, col). Compute asks
// for one product row; the block stalls items until the whole row has been
// handed to the result register.
// Result channel (result_valid / result_stall / result): one beat per column
// of the right matrix, last_in_row set on the final one. Each element is the
// sum of byte products kept modulo 256.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready;
// write only while the block is idle.
// A compute row is worked by one shared multiply-accumulate that walks the
// inner dimension per column with a registered memory read in front of it;
// when inner is 0 each column goes straight to the result register.
// Reset clears the controller and the result valid and sets every dimension
// register to 16; element stores are not cleared and hold garbage until
// loaded. A stalled result holds; the row then waits for the slot.
module byte_matrix_multiply #(
  parameter int MAX_DIM = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  bmm_pkg::bmm_in_t              item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output bmm_pkg::bmm_out_t             result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmm_pkg::DIM_W-1:0]     cfg_data
);
  import bmm_pkg::*;

  bmm_cmd_t  cmd;
  bmm_stat_t stat;

  // registers are plain flops: a write never waits
  assign cfg_ready = 1'b1;

  bmm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  bmm_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

/* rtl/bmm_ram.sv */
module bmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/bmm_datapath.sv */
`include "assert_macros.svh"

module bmm_datapath #(
  parameter int MAX_DIM = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [bmm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bmm_pkg::DIM_W-1:0]            cfg_data,
  input  bmm_pkg::bmm_in_t                     item,
  input  bmm_pkg::bmm_cmd_t                    cmd,
  output bmm_pkg::bmm_stat_t                   stat,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output bmm_pkg::bmm_out_t                    result
);
  import bmm_pkg::*;

  localparam int Depth  = MAX_DIM * MAX_DIM;
  localparam int AddrW  = $clog2(Depth);
  localparam int ColLim = (MAX_DIM < RESULT_LIMIT) ? MAX_DIM : RESULT_LIMIT;

  logic [DIM_W-1:0]  left_rows, inner_size, right_rows, right_cols;
  logic [DIM_W-1:0]  rows_eff, inner_eff, cols_eff;
  logic [ROW_W-1:0]  row_q;
  logic [DIM_W-1:0]  k;
  logic [COL_W-1:0]  c;
  logic [BYTE_W-1:0] acc;
  logic              mac_en;
  logic [BYTE_W-1:0] left_rd, right_rd;
  logic [2*BYTE_W-1:0] mul_full;
  logic [AddrW-1:0]  wr_addr, left_addr, right_addr;
  logic              load_ok, left_we, right_we;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      left_rows  <= DIM_RESET;
      inner_size <= DIM_RESET;
      right_rows <= DIM_RESET;
      right_cols <= DIM_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LEFT_ROWS:  left_rows  <= cfg_data;
        REG_INNER_SIZE: inner_size <= cfg_data;
        REG_RIGHT_ROWS: right_rows <= cfg_data;
        REG_RIGHT_COLS: right_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturate to the store size (and the per-row result limit for columns)
  assign rows_eff  = (32'(left_rows) > MAX_DIM)  ? DIM_W'(MAX_DIM) : left_rows;
  assign inner_eff = (32'(inner_size) > MAX_DIM) ? DIM_W'(MAX_DIM) : inner_size;
  assign cols_eff  = (32'(right_cols) > ColLim)  ? DIM_W'(ColLim)  : right_cols;

  assign stat.start_ok   = (item.command == CMD_COMPUTE) && (inner_size == right_rows) &&
                           (DIM_W'(item.row) < rows_eff) && (cols_eff != '0);
  assign stat.k_last     = (k == inner_eff - DIM_W'(1));
  assign stat.c_last     = (DIM_W'(c) == cols_eff - DIM_W'(1));
  assign stat.inner_zero = (inner_eff == '0);
  assign stat.out_free   = !result_valid || !result_stall;

  // element writes
  assign load_ok  = (32'(item.row) < MAX_DIM) && (32'(item.col) < MAX_DIM);
  assign left_we  = cmd.accept && load_ok && (item.command == CMD_LOAD_LEFT);
  assign right_we = cmd.accept && load_ok && (item.command == CMD_LOAD_RIGHT);
  assign wr_addr  = AddrW'(32'(item.row) * MAX_DIM + 32'(item.col));

  // element reads: left[row][k], right[k][c]
  assign left_addr  = AddrW'(32'(row_q) * MAX_DIM + 32'(k));
  assign right_addr = AddrW'(32'(k) * MAX_DIM + 32'(c));

  bmm_ram #(.WIDTH(BYTE_W), .DEPTH(Depth)) u_left (
    .clk     (clk),
    .wr_en   (left_we),
    .wr_addr (wr_addr),
    .wr_data (item.value),
    .rd_addr (left_addr),
    .rd_data (left_rd)
  );

  bmm_ram #(.WIDTH(BYTE_W), .DEPTH(Depth)) u_right (
    .clk     (clk),
    .wr_en   (right_we),
    .wr_addr (wr_addr),
    .wr_data (item.value),
    .rd_addr (right_addr),
    .rd_data (right_rd)
  );

  assign mul_full = left_rd * right_rd;

  // counters and accumulator
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_q <= item.row;
      k     <= '0;
      c     <= '0;
      acc   <= '0;
    end else if (cmd.next_col) begin
      k   <= '0;
      c   <= c + COL_W'(1);
      acc <= '0;
    end else begin
      if (cmd.issue) begin
        k <= k + DIM_W'(1);
      end
      if (mac_en) begin
        acc <= acc + mul_full[BYTE_W-1:0];
      end
    end
  end

  // read data lands in the cycle after the address
  always_ff @(posedge clk) begin
    if (rst) begin
      mac_en <= 1'b0;
    end else begin
      mac_en <= cmd.issue;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.push) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      result.product     <= acc;
      result.out_row     <= row_q;
      result.out_col     <= c;
      result.last_in_row <= stat.c_last;
    end
  end

  `BMM_ASSERT_IMP(a_push_no_overwrite, cmd.push, !result_valid || !result_stall,
                  "result overwritten while stalled")
  `BMM_ASSERT_NXT(a_mac_follows_issue, cmd.issue, mac_en,
                  "multiply-accumulate missed a read")
  `BMM_ASSERT_IMP(a_no_mac_on_push, cmd.push, !mac_en,
                  "result taken with a product still pending")

endmodule

/* rtl/bmm_ctrl.sv */
`include "assert_macros.svh"

module bmm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  bmm_pkg::bmm_stat_t stat,
  output bmm_pkg::bmm_cmd_t  cmd
);
  import bmm_pkg::*;

  bmm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid && stat.start_ok) begin
          state_next = stat.inner_zero ? ST_PUSH : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (stat.k_last) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: state_next = ST_PUSH;
      ST_PUSH: begin
        if (stat.out_free) begin
          if (stat.c_last) begin
            state_next = ST_IDLE;
          end else begin
            state_next = stat.inner_zero ? ST_PUSH : ST_ISSUE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        cmd.accept = item_valid;
        cmd.start  = item_valid && stat.start_ok;
      end
      ST_ISSUE: cmd.issue = 1'b1;
      ST_LAST: ;
      ST_PUSH: begin
        cmd.push     = stat.out_free;
        cmd.next_col = stat.out_free && !stat.c_last;
      end
      default: ;
    endcase
  end

  `BMM_ASSERT_NXT(a_issue_to_last, (state == ST_ISSUE) && stat.k_last, state == ST_LAST,
                  "dot product did not end after its last read")
  `BMM_ASSERT_NXT(a_row_done_idle, cmd.push && stat.c_last, state == ST_IDLE,
                  "controller busy after the last column")
  `BMM_ASSERT_NXT(a_start_busy, cmd.start, item_stall,
                  "item taken during a product row")

endmodule

/* dv/tb_byte_matrix_multiply.sv */
`timescale 1ns / 100ps

// Testbench for byte_matrix_multiply.
// Loads and compute beats go in on the item channel. A scoreboard predicts
// every product row and checks the result beats in order, field by field.
// Both sides idle at random. The receiver does one long hold-off so that the
// block backs up into its item input.
module tb_byte_matrix_multiply;
  import bmm_pkg::*;

  localparam int MAX_DIM      = 16;
  localparam int IDLE_PCT     = 15;
  localparam int HOLD_AFTER   = 60;         // items accepted before the long hold
  localparam int HOLD_CYCLES  = 600;
  localparam int SETTLE       = 300;        // outlasts the longest product row
  localparam int CYCLE_LIMIT  = 1_000_000;

  // the package names only the three real commands
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Shadow of the block: config copy, both element stores, products due.
  class product_scoreboard;
    logic [DIM_W-1:0]  dims [4];
    logic [BYTE_W-1:0] left_mem [MAX_DIM*MAX_DIM];
    logic [BYTE_W-1:0] right_mem [MAX_DIM*MAX_DIM];
    bmm_out_t          due [$];
    int                faults;

    function new();
      foreach (dims[i]) dims[i] = DIM_RESET;
      foreach (left_mem[i]) begin
        left_mem[i]  = '0;
        right_mem[i] = '0;
      end
      faults = 0;
    endfunction

    function void set_dim(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      dims[idx] = data;
    endfunction

    // dimension as the block uses it: capped at the store size, and the
    // column count also at the result limit
    function int span(logic [CFG_IDX_W-1:0] idx);
      int v;
      v = dims[idx];
      if (v > MAX_DIM) v = MAX_DIM;
      if (idx == REG_RIGHT_COLS && v > RESULT_LIMIT) v = RESULT_LIMIT;
      return v;
    endfunction

    function void note_item(bmm_in_t beat);
      int               addr;
      int               rows_e;
      int               inner_e;
      int               cols_e;
      logic [BYTE_W-1:0] acc;
      bmm_out_t         want;
      addr    = int'(beat.row) * MAX_DIM + int'(beat.col);
      rows_e  = span(REG_LEFT_ROWS);
      inner_e = span(REG_INNER_SIZE);
      cols_e  = span(REG_RIGHT_COLS);
      case (beat.command)
        CMD_LOAD_LEFT:  left_mem[addr]  = beat.value;
        CMD_LOAD_RIGHT: right_mem[addr] = beat.value;
        CMD_COMPUTE: begin
          // raw register compare: mismatched inner sizes give no row at all
          if (dims[REG_INNER_SIZE] == dims[REG_RIGHT_ROWS] && beat.row < rows_e) begin
            for (int c = 0; c < cols_e; c++) begin
              acc = '0;
              for (int k = 0; k < inner_e; k++)
                acc = acc + left_mem[int'(beat.row) * MAX_DIM + k]
                          * right_mem[k * MAX_DIM + c];
              want.product     = acc;
              want.out_row     = beat.row;
              want.out_col     = COL_W'(c);
              want.last_in_row = (c == cols_e - 1);
              due.push_back(want);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(bmm_out_t got);
      bmm_out_t want;
      if (due.size() == 0) begin
        $error("result beat with nothing due: product %0d row %0d col %0d last %0d",
               got.product, got.out_row, got.out_col, got.last_in_row);
        faults++;
        return;
      end
      want = due.pop_front();
      if (got.product !== want.product) begin
        $error("product: expected %0d, got %0d", want.product, got.product);
        faults++;
      end
      if (got.out_row !== want.out_row) begin
        $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
        faults++;
      end
      if (got.out_col !== want.out_col) begin
        $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
        faults++;
      end
      if (got.last_in_row !== want.last_in_row) begin
        $error("last_in_row: expected %0d, got %0d", want.last_in_row, got.last_in_row);
        faults++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  bmm_in_t              item = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  bmm_out_t             result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;

  product_scoreboard board = new();

  // which elements hold a loaded value; computes only touch these
  bit left_known [MAX_DIM*MAX_DIM];
  bit right_known [MAX_DIM*MAX_DIM];

  bit steady;            // no idling on either side while set
  int items_sent;
  int hold_left;
  bit hold_taken;
  int cycle_count;

  byte_matrix_multiply #(
    .MAX_DIM(MAX_DIM)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random stalls, plus one long hold once traffic is going so the
  // single result slot fills and the block stalls its item side.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (!hold_taken && items_sent >= HOLD_AFTER) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES - 1;
      result_stall <= 1'b1;
    end else if (steady) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // result beats are checked at the edge that takes them
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) board.check_result(result);
  end

  function automatic bmm_in_t beat_of(logic [CMD_W-1:0] cmd, int r, int c,
                                      logic [BYTE_W-1:0] v);
    bmm_in_t beat;
    beat.command = cmd;
    beat.row     = ROW_W'(r);
    beat.col     = COL_W'(c);
    beat.value   = v;
    return beat;
  endfunction

  function automatic int pick_below(int n);
    return (n == 0) ? $urandom_range(0, MAX_DIM - 1) : $urandom_range(0, n - 1);
  endfunction

  // Mostly loads into the active corner of both matrices and computes of
  // valid rows. A compute that would read an element not yet loaded is
  // turned into a load of the first such element, so every row converges.
  function automatic bmm_in_t next_item();
    bmm_in_t beat;
    int      rows_e;
    int      inner_e;
    int      cols_e;
    int      roll;
    bit      gap_found;
    rows_e  = board.span(REG_LEFT_ROWS);
    inner_e = board.span(REG_INNER_SIZE);
    cols_e  = board.span(REG_RIGHT_COLS);
    roll    = $urandom_range(0, 99);
    beat.row = ROW_W'($urandom_range(0, MAX_DIM - 1));
    beat.col = COL_W'($urandom_range(0, MAX_DIM - 1));
    case ($urandom_range(0, 9))
      0:       beat.value = 8'h00;
      1:       beat.value = 8'hFF;
      default: beat.value = BYTE_W'($urandom);
    endcase
    if (roll < 40) begin
      beat.command = CMD_COMPUTE;
      if ($urandom_range(0, 99) < 85) beat.row = ROW_W'(pick_below(rows_e));
      if (board.dims[REG_INNER_SIZE] == board.dims[REG_RIGHT_ROWS] && beat.row < rows_e) begin
        gap_found = 1'b0;
        for (int k = 0; k < inner_e && !gap_found; k++) begin
          if (!left_known[int'(beat.row) * MAX_DIM + k]) begin
            gap_found    = 1'b1;
            beat.command = CMD_LOAD_LEFT;
            beat.col     = COL_W'(k);
          end
        end
        for (int k = 0; k < inner_e && !gap_found; k++) begin
          for (int c = 0; c < cols_e && !gap_found; c++) begin
            if (!right_known[k * MAX_DIM + c]) begin
              gap_found    = 1'b1;
              beat.command = CMD_LOAD_RIGHT;
              beat.row     = ROW_W'(k);
              beat.col     = COL_W'(c);
            end
          end
        end
      end
    end else if (roll < 65) begin
      beat.command = CMD_LOAD_LEFT;
      beat.row     = ROW_W'(pick_below(rows_e));
      beat.col     = COL_W'(pick_below(inner_e));
    end else if (roll < 90) begin
      beat.command = CMD_LOAD_RIGHT;
      beat.row     = ROW_W'(pick_below(inner_e));
      beat.col     = COL_W'(pick_below(cols_e));
    end else if (roll < 96) begin
      // anywhere in either store
      beat.command = ($urandom_range(0, 1) == 0) ? CMD_LOAD_LEFT : CMD_LOAD_RIGHT;
    end else begin
      beat.command = CMD_UNUSED;
    end
    return beat;
  endfunction

  // Offer one beat from a falling edge, after random idling unless steady; hold it until taken.
  task automatic send_item(input bmm_in_t beat);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= beat;
    do @(posedge clk); while (item_stall);
    board.note_item(beat);
    items_sent++;
    if (beat.command == CMD_LOAD_LEFT)
      left_known[int'(beat.row) * MAX_DIM + int'(beat.col)] = 1'b1;
    if (beat.command == CMD_LOAD_RIGHT)
      right_known[int'(beat.row) * MAX_DIM + int'(beat.col)] = 1'b1;
  endtask

  task automatic write_dim(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.set_dim(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_dims(input logic [DIM_W-1:0] l_rows, input logic [DIM_W-1:0] inner,
                          input logic [DIM_W-1:0] r_rows, input logic [DIM_W-1:0] r_cols);
    write_dim(REG_LEFT_ROWS, l_rows);
    write_dim(REG_INNER_SIZE, inner);
    write_dim(REG_RIGHT_ROWS, r_rows);
    write_dim(REG_RIGHT_COLS, r_cols);
  endtask

  // Quiet the item side, wait out every due product, then wait out SETTLE
  // before the config is touched again.
  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (board.due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(input logic [DIM_W-1:0] l_rows, input logic [DIM_W-1:0] inner,
                           input logic [DIM_W-1:0] r_rows, input logic [DIM_W-1:0] r_cols,
                           input int count, input bit no_gaps);
    set_dims(l_rows, inner, r_rows, r_cols);
    steady = no_gaps;
    repeat (count) send_item(next_item());
    drain();
    steady = 1'b0;
  endtask

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed: 2x2 by 2x2, byte extremes ---
    set_dims(5'd2, 5'd2, 5'd2, 5'd2);
    send_item(beat_of(CMD_LOAD_LEFT, 0, 0, 8'hFF));
    send_item(beat_of(CMD_LOAD_LEFT, 0, 1, 8'hFF));
    send_item(beat_of(CMD_LOAD_LEFT, 1, 0, 8'h00));
    send_item(beat_of(CMD_LOAD_LEFT, 1, 1, 8'h01));
    send_item(beat_of(CMD_LOAD_RIGHT, 0, 0, 8'hFF));
    send_item(beat_of(CMD_LOAD_RIGHT, 0, 1, 8'h00));
    send_item(beat_of(CMD_LOAD_RIGHT, 1, 0, 8'hFF));
    send_item(beat_of(CMD_LOAD_RIGHT, 1, 1, 8'h80));
    // col and value are don't-care on compute
    send_item(beat_of(CMD_COMPUTE, 0, 15, 8'hFF));
    send_item(beat_of(CMD_COMPUTE, 1, 0, 8'h00));
    // row beyond left_rows: nothing out
    send_item(beat_of(CMD_COMPUTE, 2, 0, 8'h00));
    // unknown command is dropped
    send_item(beat_of(CMD_UNUSED, 15, 15, 8'h5A));
    // corner element of both stores
    send_item(beat_of(CMD_LOAD_LEFT, 15, 15, 8'hAA));
    send_item(beat_of(CMD_LOAD_RIGHT, 15, 15, 8'h55));
    send_item(beat_of(CMD_COMPUTE, 15, 15, 8'hFF));
    drain();

    // inner size disagrees with right rows: compute emits nothing
    set_dims(5'd2, 5'd2, 5'd3, 5'd2);
    send_item(beat_of(CMD_COMPUTE, 1, 0, 8'h00));
    drain();

    // zero inner size: a row of zero products
    set_dims(5'd2, 5'd0, 5'd0, 5'd2);
    send_item(beat_of(CMD_COMPUTE, 1, 0, 8'h00));
    drain();

    // zero columns: nothing out
    set_dims(5'd2, 5'd2, 5'd2, 5'd0);
    send_item(beat_of(CMD_COMPUTE, 0, 0, 8'h00));
    drain();

    // --- random phases; long receiver hold lands in the first ---
    run_phase(5'd4, 5'd3, 5'd3, 5'd5, 70, 1'b0);
    run_phase(5'd1, 5'd1, 5'd1, 5'd1, 30, 1'b0);
    run_phase(5'd16, 5'd4, 5'd4, 5'd16, 70, 1'b1);     // no idling anywhere
    run_phase(5'd31, 5'd2, 5'd2, 5'd31, 40, 1'b0);     // oversized, capped at 16
    run_phase(5'd2, 5'd31, 5'd31, 5'd3, 30, 1'b0);     // inner capped at 16
    run_phase(5'd16, 5'd16, 5'd16, 5'd16, 200, 1'b0);  // full size
    run_phase(5'd3, 5'd5, 5'd6, 5'd4, 20, 1'b0);       // mismatch throughout
    run_phase(5'd8, 5'd0, 5'd0, 5'd8, 15, 1'b0);
    run_phase(5'd5, 5'd6, 5'd6, 5'd0, 15, 1'b0);

    if (board.faults == 0 && board.due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/bmm_pkg.sv
rtl/bmm_ram.sv
rtl/bmm_datapath.sv
rtl/bmm_ctrl.sv
rtl/byte_matrix_multiply.sv
dv/tb_byte_matrix_multiply.sv
